>>> sv/assert_macros.svh
// Assertion helpers shared by the deque modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/deq_pkg.sv
package deq_pkg;

	localparam int WORD_W    = 32;
	localparam int CNT_OUT_W = 5;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic latch_in;
		logic exec;
		logic fetch;
		logic load_out;
	} deq_cmd_t;

	typedef struct packed {
		logic need_read;
	} deq_stat_t;

endpackage

>>> sv/deq_ram.sv
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/deq_ctrl.sv
`include "assert_macros.svh"

module deq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_valid,
	output logic                 op_stall,
	output logic                 res_valid,
	input  logic                 res_stall,
	input  deq_pkg::deq_stat_t   stat,
	output deq_pkg::deq_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_FETCH  = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;
	logic   out_free;

	assign op_stall  = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign out_free  = !res_valid_q || !res_stall;

	always_comb begin
		state_d      = state_q;
		cmd.latch_in = 1'b0;
		cmd.exec     = 1'b0;
		cmd.fetch    = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (op_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_read ? S_FETCH : S_RESULT;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	`DEQ_ASSERT_NEXT(a_accept_to_exec, op_valid && !op_stall, state_q == S_EXEC,
		"An accepted request did not start execution.")
	`DEQ_ASSERT_SAME(a_load_when_free, cmd.load_out, !res_valid_q || !res_stall,
		"A result was loaded over one that was still waiting.")
	`DEQ_ASSERT_NEXT(a_fetch_after_exec, state_q == S_EXEC && stat.need_read,
		state_q == S_FETCH, "A store read was issued without a fetch cycle.")

endmodule

>>> sv/deq_datapath.sv
`include "assert_macros.svh"

module deq_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  deq_pkg::deq_cmd_t                    cmd,
	output deq_pkg::deq_stat_t                   stat,
	input  logic [1:0]                           opcode,
	input  logic signed [deq_pkg::WORD_W-1:0]    push_value,
	output logic [1:0]                           status,
	output logic signed [deq_pkg::WORD_W-1:0]    removed_value,
	output logic [deq_pkg::CNT_OUT_W-1:0]        entry_count,
	output logic signed [deq_pkg::WORD_W-1:0]    front_value,
	output logic signed [deq_pkg::WORD_W-1:0]    back_value
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	deq_pkg::opcode_t             op_q;
	logic [deq_pkg::WORD_W-1:0]   val_q;
	logic [AW-1:0]                front_idx_q;
	logic [AW-1:0]                back_idx_q;
	logic [CW-1:0]                count_q;
	logic [deq_pkg::WORD_W-1:0]   front_val_q;
	logic [deq_pkg::WORD_W-1:0]   back_val_q;
	deq_pkg::status_t             status_q;
	logic [deq_pkg::WORD_W-1:0]   removed_q;

	logic [1:0]                   res_status_q;
	logic [deq_pkg::WORD_W-1:0]   res_removed_q;
	logic [deq_pkg::CNT_OUT_W-1:0] res_count_q;
	logic [deq_pkg::WORD_W-1:0]   res_front_q;
	logic [deq_pkg::WORD_W-1:0]   res_back_q;

	logic                         is_push;
	logic                         full;
	logic                         empty;
	logic                         refuse;
	logic                         last_word;
	logic [AW-1:0]                front_dec;
	logic [AW-1:0]                front_inc;
	logic [AW-1:0]                back_dec;
	logic [AW-1:0]                back_inc;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic [deq_pkg::WORD_W-1:0]   rd_data;
	logic [CW+deq_pkg::CNT_OUT_W-1:0] count_ext;

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
		return (idx == LAST_IDX) ? '0 : idx + AW'(1);
	endfunction

	function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] idx);
		return (idx == '0) ? LAST_IDX : idx - AW'(1);
	endfunction

	assign front_dec = idx_dec(front_idx_q);
	assign front_inc = idx_inc(front_idx_q);
	assign back_dec  = idx_dec(back_idx_q);
	assign back_inc  = idx_inc(back_idx_q);

	assign is_push   = (op_q == deq_pkg::OP_PUSH_FRONT) || (op_q == deq_pkg::OP_PUSH_BACK);
	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign refuse    = is_push ? full : empty;
	assign last_word = (count_q == ONE_CNT);

	assign stat.need_read = !is_push && !refuse && !last_word;

	assign wr_en   = cmd.exec && is_push && !full;
	assign wr_addr = (op_q == deq_pkg::OP_PUSH_FRONT) ? front_dec : back_inc;
	assign rd_en   = cmd.exec && stat.need_read;
	assign rd_addr = (op_q == deq_pkg::OP_POP_FRONT) ? front_inc : back_dec;

	deq_ram #(
		.WIDTH(deq_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(val_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q  <= deq_pkg::opcode_t'(opcode);
			val_q <= push_value;
		end
		if (cmd.exec) begin
			if (refuse) begin
				status_q <= is_push ? deq_pkg::ST_FULL : deq_pkg::ST_EMPTY;
			end else begin
				status_q <= deq_pkg::ST_DONE;
			end
			if (!is_push && !refuse) begin
				removed_q <= (op_q == deq_pkg::OP_POP_FRONT) ? front_val_q : back_val_q;
			end else begin
				removed_q <= '0;
			end
		end
		if (cmd.load_out) begin
			res_status_q  <= status_q;
			res_removed_q <= removed_q;
			res_count_q   <= count_ext[deq_pkg::CNT_OUT_W-1:0];
			res_front_q   <= front_val_q;
			res_back_q    <= back_val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_idx_q <= '0;
			back_idx_q  <= LAST_IDX;
			count_q     <= '0;
			front_val_q <= '0;
			back_val_q  <= '0;
		end else if (cmd.exec && !refuse) begin
			case (op_q)
				deq_pkg::OP_PUSH_FRONT: begin
					front_idx_q <= front_dec;
					count_q     <= count_q + ONE_CNT;
					front_val_q <= val_q;
					if (empty) begin
						back_val_q <= val_q;
					end
				end
				deq_pkg::OP_PUSH_BACK: begin
					back_idx_q <= back_inc;
					count_q    <= count_q + ONE_CNT;
					back_val_q <= val_q;
					if (empty) begin
						front_val_q <= val_q;
					end
				end
				deq_pkg::OP_POP_FRONT: begin
					front_idx_q <= front_inc;
					count_q     <= count_q - ONE_CNT;
					if (last_word) begin
						front_val_q <= '0;
						back_val_q  <= '0;
					end
				end
				deq_pkg::OP_POP_BACK: begin
					back_idx_q <= back_dec;
					count_q    <= count_q - ONE_CNT;
					if (last_word) begin
						front_val_q <= '0;
						back_val_q  <= '0;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end else if (cmd.fetch) begin
			if (op_q == deq_pkg::OP_POP_FRONT) begin
				front_val_q <= rd_data;
			end else begin
				back_val_q <= rd_data;
			end
		end
	end

	assign count_ext     = {{deq_pkg::CNT_OUT_W{1'b0}}, count_q};
	assign status        = res_status_q;
	assign removed_value = res_removed_q;
	assign entry_count   = res_count_q;
	assign front_value   = res_front_q;
	assign back_value    = res_back_q;

	`DEQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= FULL_CNT,
		"The word count exceeds the store depth.")
	`DEQ_ASSERT_SAME(a_empty_zero, empty && !cmd.fetch,
		front_val_q == '0 && back_val_q == '0,
		"An empty queue holds a nonzero front or back word.")

endmodule

>>> sv/double_ended_queue.sv
// Sequence: an accepted request passes the execute and result states; a pop that leaves
// words behind passes a fetch state between them, as the new front or back word is read
// from the single registered read port of the word store. A new request is taken only once
// the last has left the result state. A finished result may wait while the next runs.
// Reset: indices, word count and cached front and back words clear at once; the store
// contents are not cleared and are only read after being written.
module double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              op_valid,
	output logic                              op_stall,
	input  logic [1:0]                        opcode,
	input  logic signed [deq_pkg::WORD_W-1:0] push_value,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [1:0]                        status,
	output logic signed [deq_pkg::WORD_W-1:0] removed_value,
	output logic [deq_pkg::CNT_OUT_W-1:0]     entry_count,
	output logic signed [deq_pkg::WORD_W-1:0] front_value,
	output logic signed [deq_pkg::WORD_W-1:0] back_value
);

	deq_pkg::deq_cmd_t  cmd;
	deq_pkg::deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	deq_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (opcode),
		.push_value   (push_value),
		.status       (status),
		.removed_value(removed_value),
		.entry_count  (entry_count),
		.front_value  (front_value),
		.back_value   (back_value)
	);

endmodule
